>>> rtl/core/pls_pkg.sv
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [3:0] {
        ACT_APPEND    = 4'd0,
        ACT_PREPEND   = 4'd1,
        ACT_INSERT    = 4'd2,
        ACT_DROP_LAST = 4'd3,
        ACT_DROP_FRST = 4'd4,
        ACT_ERASE     = 4'd5,
        ACT_OVERWRITE = 4'd6,
        ACT_CLEAR     = 4'd7,
        ACT_READ      = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic        [3:0]        action;
        logic        [POS_W-1:0]  position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic        [LEN_W-1:0]  length;
        logic        [1:0]        status;
    } t_result;

    // Broadcast to every cell; each cell compares slot with its own index
    typedef struct packed {
        logic                     wr;
        logic                     ins;
        logic                     del;
        logic                     rd;
        logic        [IDX_W-1:0]  slot;
        logic signed [WORD_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/core/pls_cell.sv
module pls_cell (
    input  logic                              i_clk,
    input  logic [pls_pkg::IDX_W-1:0]         i_idx,
    input  logic                              i_en,
    input  pls_pkg::t_cell_ctl                i_ctl,
    input  logic signed [pls_pkg::WORD_W-1:0] i_lo,
    input  logic signed [pls_pkg::WORD_W-1:0] i_hi,
    output logic signed [pls_pkg::WORD_W-1:0] o_q
);
    import pls_pkg::*;

    logic signed [WORD_W-1:0] r_q;
    logic signed [WORD_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_en) begin
            priority if (i_ctl.wr && (i_idx == i_ctl.slot)) begin
                n_q = i_ctl.value;
            end else if (i_ctl.ins && (i_idx == i_ctl.slot)) begin
                n_q = i_ctl.value;
            end else if (i_ctl.ins && (i_idx > i_ctl.slot)) begin
                // open the gap: take the lower neighbour
                n_q = i_lo;
            end else if (i_ctl.del && (i_idx >= i_ctl.slot)) begin
                // close the gap: take the upper neighbour
                n_q = i_hi;
            end else begin
                n_q = r_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> rtl/core/pls_ctrl.sv
module pls_ctrl (
    input  pls_pkg::t_req               i_req,
    input  logic [pls_pkg::CNT_W-1:0]   i_count,
    output pls_pkg::t_cell_ctl          o_ctl,
    output logic [pls_pkg::CNT_W-1:0]   o_count,
    output logic [1:0]                  o_status
);
    import pls_pkg::*;

    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic             ins_bad;
    logic             pos_bad;
    logic [IDX_W-1:0] pos_slot;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;

    always_comb begin
        full     = (i_count == CNT_W'(CAPACITY));
        empty    = (i_count == '0);
        pos_w    = CMP_W'(i_req.position);
        cnt_w    = CMP_W'(i_count);
        ins_bad  = (pos_w == '0) || (pos_w > (cnt_w + CMP_W'(1)));
        pos_bad  = (pos_w == '0) || (pos_w > cnt_w);
        pos_slot = IDX_W'(pos_w - CMP_W'(1));
        cnt_inc  = i_count + CNT_W'(1);
        cnt_dec  = i_count - CNT_W'(1);

        o_ctl       = '0;
        o_ctl.value = i_req.value;
        o_count     = i_count;
        o_status    = ST_OK;

        unique case (i_req.action)
            ACT_APPEND: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.wr   = 1'b1;
                    o_ctl.slot = IDX_W'(i_count);
                    o_count    = cnt_inc;
                end
            end
            ACT_PREPEND: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.ins = 1'b1;
                    o_count   = cnt_inc;
                end
            end
            ACT_INSERT: begin
                if (full) begin
                    o_status = ST_FULL;
                end else if (ins_bad) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.ins  = 1'b1;
                    o_ctl.slot = pos_slot;
                    o_count    = cnt_inc;
                end
            end
            ACT_DROP_LAST: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_count = cnt_dec;
                end
            end
            ACT_DROP_FRST: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_ctl.del = 1'b1;
                    o_count   = cnt_dec;
                end
            end
            ACT_ERASE: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (pos_bad) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.del  = 1'b1;
                    o_ctl.slot = pos_slot;
                    o_count    = cnt_dec;
                end
            end
            ACT_OVERWRITE: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (pos_bad) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.wr   = 1'b1;
                    o_ctl.slot = pos_slot;
                end
            end
            ACT_CLEAR: begin
                // entries keep their words; only the length drops
                o_count = '0;
            end
            ACT_READ: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (pos_bad) begin
                    o_status = ST_RANGE;
                end else begin
                    o_ctl.rd   = 1'b1;
                    o_ctl.slot = pos_slot;
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

endmodule

>>> rtl/core/positional_list_store_core.sv
// A request accepted at a clock edge has its result strobed on o_done
// in the following cycle.
// Throughput: one request per cycle while busy is low; every cell of the entry chain
// shifts, loads or holds in the same cycle, so the chain takes a new transfer each cycle.
// Reset (i_rst_n low, synchronous): length returns to zero, busy is high during reset
// and the first cycle after it; entry words are not cleared. The receiver cannot stall.
module positional_list_store_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pls_pkg::t_req       i_req,
    output logic                o_done,
    output pls_pkg::t_result    o_result
);
    import pls_pkg::*;

    logic                     r_ready;
    logic [CNT_W-1:0]         r_count;
    logic                     r_done;
    t_result                  r_result;

    logic                     accept;
    t_cell_ctl                ctl;
    logic [CNT_W-1:0]         n_count;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] rd_value;
    logic signed [WORD_W-1:0] w_entry [CAPACITY];

    assign busy   = !r_ready;
    assign accept = start && !busy;

    pls_ctrl u_ctrl (
        .i_req    (i_req),
        .i_count  (r_count),
        .o_ctl    (ctl),
        .o_count  (n_count),
        .o_status (status)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [WORD_W-1:0] lo;
        logic signed [WORD_W-1:0] hi;

        if (g == 0) begin : g_first
            assign lo = w_entry[g];
        end else begin : g_mid_lo
            assign lo = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign hi = w_entry[g];
        end else begin : g_mid_hi
            assign hi = w_entry[g+1];
        end

        pls_cell u_cell (
            .i_clk (i_clk),
            .i_idx (IDX_W'(g)),
            .i_en  (accept),
            .i_ctl (ctl),
            .i_lo  (lo),
            .i_hi  (hi),
            .o_q   (w_entry[g])
        );
    end

    assign rd_value = ctl.rd ? w_entry[ctl.slot] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_result.read_value <= rd_value;
            r_result.length     <= LEN_W'(n_count);
            r_result.status     <= status;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> bench/positional_list_store_checker.sv
module positional_list_store_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  pls_pkg::t_req    i_req,
    input  logic             i_done,
    input  pls_pkg::t_result i_result,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending,
    output int unsigned      o_list_len,
    output int unsigned      o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int unsigned EXP_DEPTH = 4;

    logic signed [WORD_W-1:0] shadow_words [CAPACITY];
    int unsigned              shadow_len;
    t_result                  exp_fifo [EXP_DEPTH];
    logic [1:0]               exp_rd_ptr;
    logic [1:0]               exp_wr_ptr;
    int unsigned              exp_level;
    int unsigned              mismatch_total;
    int unsigned              checked_total;

    initial begin
        foreach (shadow_words[k]) shadow_words[k] = '0;
        shadow_len     = 0;
        exp_rd_ptr     = '0;
        exp_wr_ptr     = '0;
        exp_level      = 0;
        mismatch_total = 0;
        checked_total  = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        o_list_len     = 0;
        o_checked      = 0;
    end

    // Apply one request to the shadow list and return the result it should give
    function automatic t_result apply_request(input t_req req);
        t_result     res;
        int unsigned pos;
        int unsigned idx;
        res.read_value = '0;
        res.status     = ST_OK;
        pos            = 32'(req.position);
        case (req.action)
            ACT_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[IDX_W'(shadow_len)] = req.value;
                    shadow_len++;
                end
            end
            ACT_PREPEND, ACT_INSERT: begin
                if (req.action == ACT_PREPEND) pos = 1;
                if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (pos < 1 || pos > shadow_len + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    // open a gap: later entries move up one place
                    for (idx = shadow_len; idx > pos - 1; idx--)
                        shadow_words[IDX_W'(idx)] = shadow_words[IDX_W'(idx - 1)];
                    shadow_words[IDX_W'(pos - 1)] = req.value;
                    shadow_len++;
                end
            end
            ACT_DROP_LAST, ACT_DROP_FRST: begin
                if (req.action == ACT_DROP_FRST) pos = 1;
                else pos = shadow_len;
            end
            ACT_ERASE, ACT_OVERWRITE, ACT_READ: begin
            end
            ACT_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
            end
        endcase
        case (req.action)
            ACT_DROP_LAST, ACT_DROP_FRST, ACT_ERASE, ACT_OVERWRITE, ACT_READ: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos < 1 || pos > shadow_len) begin
                    res.status = ST_RANGE;
                end else if (req.action == ACT_OVERWRITE) begin
                    shadow_words[IDX_W'(pos - 1)] = req.value;
                end else if (req.action == ACT_READ) begin
                    res.read_value = shadow_words[IDX_W'(pos - 1)];
                end else begin
                    // close the gap: later entries move down one place
                    for (idx = pos - 1; idx + 1 < shadow_len; idx++)
                        shadow_words[IDX_W'(idx)] = shadow_words[IDX_W'(idx + 1)];
                    shadow_len--;
                end
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(shadow_len);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            shadow_len = 0;
            exp_rd_ptr = '0;
            exp_wr_ptr = '0;
            exp_level  = 0;
        end else begin
            // results strobed in this cycle belong to requests taken earlier
            if (i_done) begin
                if (exp_level == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result: read_value %0d length %0d status %0d",
                             $time, i_result.read_value, i_result.length, i_result.status);
                end else begin
                    want       = exp_fifo[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 2'd1;
                    exp_level--;
                    checked_total++;
                    if (i_result.read_value !== want.read_value) begin
                        mismatch_total++;
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, want.read_value, i_result.read_value);
                    end
                    if (i_result.length !== want.length) begin
                        mismatch_total++;
                        $display("%0t: length mismatch: expected %0d, actual %0d",
                                 $time, want.length, i_result.length);
                    end
                    if (i_result.status !== want.status) begin
                        mismatch_total++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_result.status);
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (exp_level == EXP_DEPTH) begin
                    mismatch_total++;
                    $display("%0t: too many requests without a result", $time);
                end else begin
                    exp_fifo[exp_wr_ptr] = apply_request(i_req);
                    exp_wr_ptr           = exp_wr_ptr + 2'd1;
                    exp_level++;
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_checked    <= checked_total;
        o_pending    <= exp_level;
        o_list_len   <= shadow_len;
    end

endmodule

>>> bench/positional_list_store_core_tb.sv
module positional_list_store_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam logic [3:0]  ACT_UNUSED_LO = 4'd9;
    localparam logic [3:0]  ACT_UNUSED_HI = 4'd15;
    localparam int unsigned STALL_LIMIT   = 200;
    localparam int unsigned SEGMENT_ITEMS = 50;

    typedef enum int {MIX_GROW = 0, MIX_SHRINK = 1, MIX_EVEN = 2} t_mix;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_req    req     = '0;
    logic    done;
    t_result result;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned list_len;
    int unsigned checked;

    bit          idle_on = 1'b1;
    int unsigned directed_sent = 0;
    int unsigned random_sent   = 0;
    int unsigned stall_cycles  = 0;

    // weights per slot: append, prepend, insert, drop last, drop first, erase,
    // overwrite, clear, read, unused code
    int unsigned mix_weight [3][10] = '{
        '{35, 15, 25,  3,  2,  3,  4, 0, 12, 1},
        '{ 5,  3,  3, 25, 20, 22,  5, 1, 15, 1},
        '{15, 10, 15,  8,  7, 10, 10, 2, 20, 3}
    };
    logic [3:0] slot_action [9] = '{ACT_APPEND, ACT_PREPEND, ACT_INSERT, ACT_DROP_LAST,
                                    ACT_DROP_FRST, ACT_ERASE, ACT_OVERWRITE, ACT_CLEAR,
                                    ACT_READ};
    t_mix segment_mix [8] = '{MIX_GROW, MIX_GROW, MIX_EVEN, MIX_SHRINK,
                              MIX_SHRINK, MIX_EVEN, MIX_GROW, MIX_EVEN};

    positional_list_store_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (req),
        .o_done   (done),
        .o_result (result)
    );

    positional_list_store_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_done       (done),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_req req_of(input logic [3:0] act, input int unsigned pos,
                                    input logic [WORD_W-1:0] word);
        t_req r;
        r.action   = act;
        r.position = POS_W'(pos);
        r.value    = word;
        return r;
    endfunction

    // len lags the accepted stream by one transfer; close enough to steer positions
    function automatic t_req random_request(input t_mix mix, input int unsigned len);
        int unsigned roll;
        int unsigned acc;
        int unsigned slot;
        int unsigned lim;
        int unsigned pos;
        logic [3:0]  act;
        roll = $urandom_range(99);
        slot = 0;
        acc  = mix_weight[2'(mix)][4'(slot)];
        while (roll >= acc) begin
            slot++;
            acc += mix_weight[2'(mix)][4'(slot)];
        end
        if (slot < 9) act = slot_action[4'(slot)];
        else act = 4'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
        lim  = (act == ACT_INSERT) ? len + 1 : ((len == 0) ? 1 : len);
        roll = $urandom_range(99);
        if (roll < 15) begin
            pos = $urandom_range(127, 0);
        end else if (roll < 30) begin
            case ($urandom_range(2))
                0:       pos = 1;
                1:       pos = len;
                default: pos = len + 1;
            endcase
        end else begin
            pos = $urandom_range(lim, 1);
        end
        return req_of(act, pos, $urandom);
    endfunction

    // hold the request until the block takes it, then maybe idle with start low
    task automatic issue(input t_req r);
        start <= 1'b1;
        req   <= r;
        do @(posedge i_clk); while (busy);
        if (idle_on && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_directed(input logic [3:0] act, input int unsigned pos,
                                 input logic [WORD_W-1:0] word);
        issue(req_of(act, pos, word));
        directed_sent++;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: empty status comes before position checks; inserts at 0 and 2 are out of range
        send_directed(ACT_DROP_LAST, 0, 32'h0000_0001);
        send_directed(ACT_DROP_FRST, 0, 32'h0000_0002);
        send_directed(ACT_ERASE, 1, 32'h0000_0003);
        send_directed(ACT_OVERWRITE, 1, 32'h0000_0004);
        send_directed(ACT_READ, 0, 32'h0000_0005);
        send_directed(ACT_INSERT, 0, 32'h0000_0006);
        send_directed(ACT_INSERT, 2, 32'h0000_0007);
        // build a short list holding the value extremes
        send_directed(ACT_INSERT, 1, 32'h8000_0000);
        send_directed(ACT_APPEND, 0, 32'h7FFF_FFFF);
        send_directed(ACT_PREPEND, 0, 32'hFFFF_FFFF);
        send_directed(ACT_INSERT, 4, 32'h5A5A_5A5A);
        send_directed(ACT_READ, 0, 32'h0);
        send_directed(ACT_READ, 5, 32'h0);
        send_directed(ACT_READ, 127, 32'h0);
        send_directed(ACT_READ, 1, 32'h0);
        send_directed(ACT_READ, 4, 32'h0);
        send_directed(ACT_OVERWRITE, 2, 32'h0);
        send_directed(ACT_ERASE, 5, 32'h0);
        send_directed(ACT_ERASE, 2, 32'h0);
        send_directed(ACT_READ, 2, 32'h0);
        send_directed(ACT_DROP_FRST, 0, 32'h0);
        send_directed(ACT_DROP_LAST, 0, 32'h0);
        send_directed(ACT_UNUSED_HI, 127, 32'hFFFF_FFFF);
        send_directed(ACT_CLEAR, 0, 32'h0);
        send_directed(ACT_READ, 1, 32'h0);

        // growth segments weight the mix toward adding entries, shrink segments toward removing them
        foreach (segment_mix[seg]) begin
            if (seg == $size(segment_mix) - 1) idle_on = 1'b0;
            repeat (SEGMENT_ITEMS) begin
                issue(random_request(segment_mix[seg], list_len));
                random_sent++;
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d directed and %0d random requests, %0d results compared.",
                 directed_sent, random_sent, checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
